// ===== src/drs_pkg.sv =====
// Shared types and constants for the disjoint range set table.
`timescale 1ns / 1ps
package drs_pkg;

  localparam int SEQ_W          = 63;
  localparam int CMD_W          = 2;
  localparam int ST_W           = 2;
  localparam int SR_W           = 6;
  localparam int MAX_RANGES_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TRIM,
    CELL_DEL,
    CELL_INS
  } cell_op_t;

  typedef struct packed {
    logic [SEQ_W-1:0] s;
    logic [SEQ_W-1:0] e;
  } cell_data_t;

  typedef struct packed {
    cell_op_t         op;
    logic             del_dead;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    cell_data_t       ins;
  } cell_ctrl_t;

  typedef struct packed {
    logic touch;
    logic dead;
    logic split;
    logic present;
    logic contained;
    logic first;
  } cell_flags_t;

endpackage

// ===== src/drs_cell.sv =====
// One table entry: holds a range, compares it against the command range, shifts with neighbors.
`timescale 1ns / 1ps
module drs_cell (
  input  logic                clk,
  input  logic                valid,
  input  drs_pkg::cell_ctrl_t ctrl,
  input  drs_pkg::cell_data_t left,
  input  drs_pkg::cell_data_t right,
  input  logic                seen_in,
  output logic                seen_out,
  output drs_pkg::cell_data_t data,
  output drs_pkg::cell_flags_t flags
);
  import drs_pkg::*;

  logic touch, dead, split, after, sel;

  assign touch = valid && (data.e >= ctrl.a) && (data.s <= ctrl.b);
  assign dead  = valid && (data.s >= ctrl.a) && (data.e <= ctrl.b);
  assign split = valid && (data.s < ctrl.a) && (data.e > ctrl.b);
  // insertion point: first free slot or first range starting past the key
  assign after = !valid || (data.s > ctrl.ins.s);

  assign sel      = (ctrl.op == CELL_DEL) ? (ctrl.del_dead ? dead : touch) : after;
  assign seen_out = seen_in | sel;

  always_comb begin
    flags.touch     = touch;
    flags.dead      = dead;
    flags.split     = split;
    flags.present   = valid && (data.s <= ctrl.a) && (ctrl.a < data.e);
    flags.contained = valid && (data.s <= ctrl.a) && (ctrl.b <= data.e);
    flags.first     = sel && !seen_in;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: ;
      CELL_TRIM: begin
        if (valid && data.s < ctrl.a && data.e > ctrl.a) data.e <= ctrl.a;
        if (valid && data.s >= ctrl.a && data.s < ctrl.b && data.e > ctrl.b) data.s <= ctrl.b;
      end
      // close the gap: everything from the first selected cell up takes its upper neighbor
      CELL_DEL: if (seen_out) data <= right;
      CELL_INS: begin
        if (seen_in) data <= left;
        else if (sel) data <= ctrl.ins;
      end
    endcase
  end

endmodule

// ===== src/disjoint_range_set_table.sv =====
// Top level: sorted table of disjoint ranges built as a row of shifting cells.
//
//   channel   direction  handshake             payload
//   command   in         start & !busy         cmd, range_start, range_end
//   result    out        done (one cycle)      hit, status, stored_ranges
//
// Query, an empty range and a refusal are answered from the evaluation state;
// an add then absorbs and deletes, one at a time, the k stored ranges it merges
// and inserts the merged range; a remove trims partly covered ranges while it
// evaluates, inserts a split's upper piece, then deletes the d it covers. The
// row deletes or inserts one entry a cycle.
// Reset empties the table at once. The result beat cannot be stalled; busy
// falls in the cycle that carries it.
`timescale 1ns / 1ps
module disjoint_range_set_table #(
  parameter int MAX_RANGES = drs_pkg::MAX_RANGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [drs_pkg::CMD_W-1:0] cmd,
  input  logic [drs_pkg::SEQ_W-1:0] range_start,
  input  logic [drs_pkg::SEQ_W-1:0] range_end,
  output logic                      busy,
  output logic                      done,
  output logic                      hit,
  output logic [drs_pkg::ST_W-1:0]  status,
  output logic [drs_pkg::SR_W-1:0]  stored_ranges
);
  import drs_pkg::*;

  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_ADD, S_SPLIT, S_DEL} state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [SEQ_W-1:0] a_q, b_q, acc_s, acc_e;
  logic [CW-1:0]    count;
  logic             full;

  cell_ctrl_t       ctrl;
  cell_data_t       cdata  [MAX_RANGES];
  cell_flags_t      cflags [MAX_RANGES];
  logic [MAX_RANGES:0]   seen;
  logic [MAX_RANGES-1:0] cvalid;

  logic             any_touch, any_dead, any_split, any_present, any_contained;
  logic [SEQ_W-1:0] split_e, ft_s, ft_e;

  assign seen[0] = 1'b0;
  assign full    = (count == CW'(MAX_RANGES));

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    cell_data_t left_d, right_d;
    assign cvalid[i] = (CW'(i) < count);
    if (i == 0) begin : g_lo
      assign left_d = cdata[0];
    end else begin : g_lm
      assign left_d = cdata[i-1];
    end
    if (i == MAX_RANGES - 1) begin : g_hi
      assign right_d = cdata[i];
    end else begin : g_hm
      assign right_d = cdata[i+1];
    end
    drs_cell u_cell (
      .clk      (clk),
      .valid    (cvalid[i]),
      .ctrl     (ctrl),
      .left     (left_d),
      .right    (right_d),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .data     (cdata[i]),
      .flags    (cflags[i])
    );
  end

  always_comb begin
    any_touch     = 1'b0;
    any_dead      = 1'b0;
    any_split     = 1'b0;
    any_present   = 1'b0;
    any_contained = 1'b0;
    split_e       = '0;
    ft_s          = '0;
    ft_e          = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      any_touch     = any_touch | cflags[i].touch;
      any_dead      = any_dead | cflags[i].dead;
      any_split     = any_split | cflags[i].split;
      any_present   = any_present | cflags[i].present;
      any_contained = any_contained | cflags[i].contained;
      if (cflags[i].split) split_e = split_e | cdata[i].e;
      if (cflags[i].first) begin
        ft_s = ft_s | cdata[i].s;
        ft_e = ft_e | cdata[i].e;
      end
    end
  end

  always_comb begin
    ctrl.op       = CELL_HOLD;
    ctrl.del_dead = 1'b0;
    ctrl.a        = a_q;
    ctrl.b        = b_q;
    ctrl.ins.s    = acc_s;
    ctrl.ins.e    = acc_e;
    unique case (state)
      S_IDLE: ;
      S_EVAL: begin
        if (cmd_q == CMD_REMOVE && b_q > a_q && !(any_split && full)) ctrl.op = CELL_TRIM;
      end
      S_ADD:   ctrl.op = any_touch ? CELL_DEL : CELL_INS;
      S_SPLIT: ctrl.op = CELL_INS;
      S_DEL: begin
        if (any_dead) begin
          ctrl.op       = CELL_DEL;
          ctrl.del_dead = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd_t'(cmd);
            a_q   <= range_start;
            b_q   <= range_end;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          hit    <= 1'b0;
          status <= ST_DONE;
          if (b_q <= a_q) begin
            if (cmd_q == CMD_QUERY) status <= ST_EMPTY;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            unique case (cmd_q)
              CMD_ADD: begin
                if (!any_touch && full) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end else begin
                  acc_s <= a_q;
                  acc_e <= b_q;
                  state <= S_ADD;
                end
              end
              CMD_REMOVE: begin
                if (any_split && full) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end else if (any_split) begin
                  // upper piece of the split range goes in next cycle
                  hit   <= any_present;
                  acc_s <= b_q;
                  acc_e <= split_e;
                  state <= S_SPLIT;
                end else begin
                  hit   <= any_present;
                  state <= S_DEL;
                end
              end
              CMD_QUERY: begin
                hit   <= any_contained;
                done  <= 1'b1;
                state <= S_IDLE;
              end
              CMD_NONE: begin
                done  <= 1'b1;
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD: begin
          if (any_touch) begin
            // absorb the lowest touching range and drop it from the row
            if (ft_s < acc_s) acc_s <= ft_s;
            if (ft_e > acc_e) acc_e <= ft_e;
            count <= count - CW'(1);
          end else begin
            count <= count + CW'(1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SPLIT: begin
          count <= count + CW'(1);
          state <= S_DEL;
        end
        S_DEL: begin
          if (any_dead) begin
            count <= count - CW'(1);
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign stored_ranges = SR_W'(count);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_RANGES))
    else $error("range count above table size");

  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_empty_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> !hit)
    else $error("hit reported for empty query");

endmodule

// ===== sim/tb_disjoint_range_set_table.sv =====
// Self-checking testbench for the disjoint range set table.
`timescale 1ns / 1ps
module tb_disjoint_range_set_table;
  import drs_pkg::*;

  localparam int NMAX = MAX_RANGES_DEF;
  localparam int N_RANDOM = 350;
  localparam int STALL_LIMIT = 2000;
  localparam logic [SEQ_W-1:0] SEQ_TOP = {SEQ_W{1'b1}};

  typedef struct packed {
    logic             hit;
    status_t          status;
    logic [SR_W-1:0]  stored_ranges;
  } range_answer_t;

  typedef struct {
    cmd_t             cmd;
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic             typed;
    range_answer_t    ans;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CMD_W-1:0] cmd = '0;
  logic [SEQ_W-1:0] range_start = '0;
  logic [SEQ_W-1:0] range_end = '0;
  logic busy, done, hit;
  logic [ST_W-1:0] status;
  logic [SR_W-1:0] stored_ranges;

  disjoint_range_set_table u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .range_start(range_start), .range_end(range_end),
    .busy(busy), .done(done), .hit(hit), .status(status),
    .stored_ranges(stored_ranges)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the range table.
  logic [SEQ_W-1:0] set_lo [NMAX];
  logic [SEQ_W-1:0] set_hi [NMAX];
  int set_count;

  range_answer_t answers_due [$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int n_add = 0, n_rem = 0, n_qry = 0, n_full = 0;

  function automatic status_t merge_range(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    int lo, hi, k;
    lo = 0;
    while (lo < set_count && set_hi[lo] < a) lo++;
    hi = lo;
    while (hi < set_count && set_lo[hi] <= b) hi++;
    k = hi - lo;
    if (k == 0) begin
      if (set_count >= NMAX) return ST_FULL;
      for (int i = set_count; i > lo; i--) begin
        set_lo[i] = set_lo[i-1];
        set_hi[i] = set_hi[i-1];
      end
      set_lo[lo] = a;
      set_hi[lo] = b;
      set_count++;
      return ST_DONE;
    end
    if (a < set_lo[lo]) set_lo[lo] = a;
    set_hi[lo] = (set_hi[hi-1] > b) ? set_hi[hi-1] : b;
    for (int i = hi; i < set_count; i++) begin
      set_lo[i-k+1] = set_lo[i];
      set_hi[i-k+1] = set_hi[i];
    end
    set_count -= k - 1;
    return ST_DONE;
  endfunction

  function automatic status_t carve_range(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] nlo [NMAX];
    logic [SEQ_W-1:0] nhi [NMAX];
    int n;
    n = 0;
    for (int i = 0; i < set_count; i++) begin
      if (set_lo[i] < a) begin
        if (n >= NMAX) return ST_FULL;
        nlo[n] = set_lo[i];
        nhi[n] = (set_hi[i] < a) ? set_hi[i] : a;
        n++;
      end
      if (set_hi[i] > b) begin
        if (n >= NMAX) return ST_FULL;
        nlo[n] = (set_lo[i] > b) ? set_lo[i] : b;
        nhi[n] = set_hi[i];
        n++;
      end
    end
    set_lo = nlo;
    set_hi = nhi;
    set_count = n;
    return ST_DONE;
  endfunction

  function automatic range_answer_t apply_range_cmd(cmd_t c, logic [SEQ_W-1:0] a,
                                                    logic [SEQ_W-1:0] b);
    range_answer_t r;
    logic was;
    r.hit = 1'b0;
    r.status = ST_DONE;
    case (c)
      CMD_ADD: if (b > a) r.status = merge_range(a, b);
      CMD_REMOVE: if (b > a) begin
        was = 1'b0;
        for (int i = 0; i < set_count; i++)
          if (set_lo[i] <= a && a < set_hi[i]) was = 1'b1;
        r.status = carve_range(a, b);
        r.hit = was && r.status == ST_DONE;
      end
      CMD_QUERY: if (b <= a) r.status = ST_EMPTY;
        else for (int i = 0; i < set_count; i++)
          if (set_lo[i] <= a && b <= set_hi[i]) r.hit = 1'b1;
      default: ;
    endcase
    r.stored_ranges = set_count[SR_W-1:0];
    return r;
  endfunction

  function automatic range_answer_t ans_of(logic h, status_t s, int n);
    range_answer_t r;
    r.hit = h;
    r.status = s;
    r.stored_ranges = n[SR_W-1:0];
    return r;
  endfunction

  // Check each result beat against the oldest expected answer.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        range_answer_t e;
        e = answers_due.pop_front();
        if (e.status == ST_FULL) n_full++;
        if (hit !== e.hit || status !== e.status || stored_ranges !== e.stored_ranges) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp hit=%0b status=%0d ranges=%0d, got %0b %0d %0d",
                     results_seen, e.hit, e.status, e.stored_ranges,
                     hit, status, stored_ranges);
        end
      end
    end
  end

  // Watchdog on cycles without an accepted beat.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** disjoint_range_set_table: FAILED **");
      $finish;
    end
  end

  // Hold start until the accepting edge; drop it only when a gap follows.
  task automatic issue_cmd(cmd_t c, logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                           bit typed, range_answer_t want);
    range_answer_t r;
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    range_start <= a;
    range_end <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_range_cmd(c, a, b);
    if (c == CMD_ADD) n_add++;
    else if (c == CMD_REMOVE) n_rem++;
    else if (c == CMD_QUERY) n_qry++;
    if (typed && r != want) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row disagrees with predictor");
    end
    answers_due.push_back(r);
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq(int span);
    logic [SEQ_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SEQ_W'({$urandom, $urandom});
      1: v = SEQ_TOP - $urandom_range(0, 3);
      default: v = $urandom_range(0, span);
    endcase
    return v;
  endfunction

  cmd_row_t rows [$];

  function automatic cmd_row_t mk(cmd_t c, logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                  bit typed = 0, logic h = 0, status_t s = ST_DONE,
                                  int n = 0);
    cmd_row_t r;
    r.cmd = c; r.a = a; r.b = b; r.typed = typed;
    r.ans.hit = h; r.ans.status = s; r.ans.stored_ranges = n[SR_W-1:0];
    return r;
  endfunction

  initial begin
    cmd_t c;
    logic [SEQ_W-1:0] a, b;
    range_answer_t none;
    int span;
    set_count = 0;
    none = '{1'b0, ST_DONE, '0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(mk(CMD_QUERY, 0, 1, 1, 0, ST_DONE, 0));
    rows.push_back(mk(CMD_QUERY, 5, 5, 1, 0, ST_EMPTY, 0));
    rows.push_back(mk(CMD_QUERY, SEQ_TOP, 0, 1, 0, ST_EMPTY, 0));
    rows.push_back(mk(CMD_ADD, 7, 3, 1, 0, ST_DONE, 0));
    rows.push_back(mk(CMD_REMOVE, 9, 9, 1, 0, ST_DONE, 0));
    rows.push_back(mk(CMD_NONE, 1, 100, 1, 0, ST_DONE, 0));
    rows.push_back(mk(CMD_ADD, 0, 10, 1, 0, ST_DONE, 1));
    rows.push_back(mk(CMD_ADD, SEQ_TOP - 1, SEQ_TOP, 1, 0, ST_DONE, 2));
    rows.push_back(mk(CMD_ADD, 10, 20));
    rows.push_back(mk(CMD_ADD, 30, 40));
    rows.push_back(mk(CMD_ADD, 15, 35));
    rows.push_back(mk(CMD_QUERY, 0, 40));
    rows.push_back(mk(CMD_QUERY, 0, 41));
    rows.push_back(mk(CMD_REMOVE, 5, 8));
    rows.push_back(mk(CMD_REMOVE, 4, 6));
    rows.push_back(mk(CMD_REMOVE, 0, SEQ_TOP));
    rows.push_back(mk(CMD_QUERY, SEQ_TOP - 1, SEQ_TOP));
    rows.push_back(mk(CMD_REMOVE, SEQ_TOP - 1, SEQ_TOP));
    foreach (rows[i]) issue_cmd(rows[i].cmd, rows[i].a, rows[i].b, rows[i].typed, rows[i].ans);

    // Fill the table with isolated ranges to reach the full cases.
    for (int i = 0; i < NMAX; i++) issue_cmd(CMD_ADD, 100 * i, 100 * i + 10, 0, none);
    issue_cmd(CMD_ADD, 5000, 5010, 1, ans_of(1'b0, ST_FULL, NMAX));
    issue_cmd(CMD_REMOVE, 102, 104, 1, ans_of(1'b0, ST_FULL, NMAX));
    issue_cmd(CMD_ADD, 5, 195, 0, none);
    issue_cmd(CMD_REMOVE, 0, SEQ_TOP, 0, none);

    // Random part: half the commands draw from a small dense span so merges and splits happen.
    for (int i = 0; i < N_RANDOM; i++) begin
      span = (i % 100 < 50) ? 300 : 5000;
      case ($urandom_range(0, 19))
        0: c = CMD_NONE;
        1, 2, 3, 4, 5, 6, 7, 8: c = CMD_ADD;
        9, 10, 11, 12, 13: c = CMD_REMOVE;
        default: c = CMD_QUERY;
      endcase
      a = pick_seq(span);
      if ($urandom_range(0, 9) == 0) b = pick_seq(span);
      else b = (a > SEQ_TOP - 40) ? SEQ_TOP : a + $urandom_range(0, 40);
      issue_cmd(c, a, b, 0, none);
      if (i % 100 == 99) issue_cmd(CMD_REMOVE, 0, SEQ_TOP, 0, none);
    end
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d adds, %0d removes, %0d queries; %0d refusals on a full table",
             n_add, n_rem, n_qry, n_full);
    $display("%0d result beats checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) $display("** disjoint_range_set_table: PASSED **");
    else $display("** disjoint_range_set_table: FAILED **");
    $finish;
  end
endmodule

// ===== sim.f =====
src/drs_pkg.sv
src/drs_cell.sv
src/disjoint_range_set_table.sv
sim/tb_disjoint_range_set_table.sv
